FILE: rtl/pts_pkg.sv
// Package for the priority task scheduler: command and mode codes, the
// command word that travels from the front queue to the executor, and helpers.
// No dependencies.
package pts_pkg;

  // Fixed field widths of the command and result words and the priority register.
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned SEM_ID_W    = 3;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned RUN_TASK_W  = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned PRIO_TASKS  = PRIO_W / LEVEL_W;
  localparam logic [PRIO_W-1:0] PRIO_RESET = 16'h1555;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_TASKS      = 8;
  localparam int unsigned DEF_LEVELS     = 4;
  localparam int unsigned DEF_SEMAPHORES = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_SCHEDULE = 3'd2,
    CMD_DELAY    = 3'd3,
    CMD_TAKE     = 3'd4,
    CMD_GIVE     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_WAITING = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    TAKE_ACQUIRED  = 2'd0,
    TAKE_NOT_AVAIL = 2'd1,
    TAKE_BLOCKED   = 2'd2
  } take_status_e;

  typedef enum logic [1:0] {
    QOP_NONE  = 2'd0,
    QOP_ENQ   = 2'd1,
    QOP_DEQ   = 2'd2,
    QOP_CLEAR = 2'd3
  } qop_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_START_Q,
    ST_TICK_DLY,
    ST_TICK_SEM,
    ST_GIVE_SWEEP,
    ST_SCHED_PICK,
    ST_DONE
  } state_e;

  // One command word as accepted on the input side.
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SEM_ID_W-1:0] sem_id;
    logic [TICKS_W-1:0]  wait_ticks;
    logic                wait_forever;
  } word_t;

  // Front queue head as seen by the executor.
  typedef struct packed {
    logic  valid;
    word_t word;
  } front_head_t;

  // Priority level of a task; tasks beyond the register read level zero.
  function automatic logic [LEVEL_W-1:0] level_of(input logic [PRIO_W-1:0] prio,
                                                  input int unsigned t);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    if (t < PRIO_TASKS) begin
      lvl = prio[LEVEL_W*t +: LEVEL_W];
    end
    return lvl;
  endfunction

endpackage

FILE: rtl/pts_front.sv
// Front part of the scheduler: accepts command words and holds them in a
// two-entry queue until the executor takes them. Uses pts_pkg.
module pts_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  pts_pkg::word_t               word_i,
  output logic                         busy_o,
  output pts_pkg::front_head_t         head_o,
  input  logic                         pop_i
);
  import pts_pkg::*;

  word_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != 2'd0);

  // Head word goes to the executor; unknown commands are passed on as they are.
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.word  = mem_q[rd_ptr_q];

  // Storage of the words.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/pts_ready_q.sv
// Ready queues of the scheduler: one FIFO per priority level with a count,
// tail insert and compacting removal of a named task. Uses pts_pkg.
module pts_ready_q #(
  parameter int unsigned TASKS           = pts_pkg::DEF_TASKS,
  parameter int unsigned PRIORITY_LEVELS = pts_pkg::DEF_LEVELS,
  parameter int unsigned TIDW            = $clog2(TASKS + 1),
  parameter int unsigned CW              = $clog2(TASKS + 1)
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  pts_pkg::qop_e                                op_i,
  input  logic [TIDW-1:0]                              task_i,
  input  logic [pts_pkg::LEVEL_W-1:0]                  level_i,
  output logic [PRIORITY_LEVELS-1:0][CW-1:0]           cnt_o,
  output logic [PRIORITY_LEVELS-1:0][TIDW-1:0]         head_o
);
  import pts_pkg::*;

  localparam int unsigned TIW  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned LVLW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

  logic [TIDW-1:0] q_q [PRIORITY_LEVELS][TASKS];
  logic [PRIORITY_LEVELS-1:0][CW-1:0] cnt_q;
  logic            in_range;
  logic [LVLW-1:0] lv;
  logic            found;
  logic [TIW-1:0]  pos;

  assign in_range = (int'(level_i) < PRIORITY_LEVELS);
  assign lv       = LVLW'(level_i);
  assign cnt_o    = cnt_q;

  always_comb begin
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      head_o[l] = q_q[l][0];
    end
  end

  // First slot of the level's queue that holds the task.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int k = TASKS - 1; k >= 0; k--) begin
      if ((k < int'(cnt_q[lv])) && (q_q[lv][k] == task_i)) begin
        found = 1'b1;
        pos   = TIW'(k);
      end
    end
  end

  // Queue entries: tail write, or shift down over the removed slot.
  always_ff @(posedge clk_i) begin
    if (in_range) begin
      if (op_i == QOP_ENQ && int'(cnt_q[lv]) < TASKS) begin
        q_q[lv][cnt_q[lv][TIW-1:0]] <= task_i;
      end else if (op_i == QOP_DEQ && found) begin
        for (int k = 0; k < TASKS - 1; k++) begin
          if (k >= int'(pos)) begin
            q_q[lv][k] <= q_q[lv][k+1];
          end
        end
      end
    end
  end

  // Counts per level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (op_i == QOP_CLEAR) begin
      cnt_q <= '0;
    end else if (in_range) begin
      if (op_i == QOP_ENQ && int'(cnt_q[lv]) < TASKS) begin
        cnt_q[lv] <= cnt_q[lv] + CW'(1);
      end else if (op_i == QOP_DEQ && found) begin
        cnt_q[lv] <= cnt_q[lv] - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/pts_back.sv
// Back part of the scheduler: a sequencer that carries out one command word
// at a time over the task table, semaphores and ready queues.
// Uses pts_pkg and pts_ready_q.
module pts_back #(
  parameter int unsigned TASKS           = pts_pkg::DEF_TASKS,
  parameter int unsigned PRIORITY_LEVELS = pts_pkg::DEF_LEVELS,
  parameter int unsigned SEMAPHORES      = pts_pkg::DEF_SEMAPHORES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [pts_pkg::PRIO_W-1:0]          prio_i,
  input  pts_pkg::front_head_t                head_i,
  output logic                                pop_o,
  output logic                                done_o,
  output logic [pts_pkg::RUN_TASK_W-1:0]      running_task_o,
  output logic                                switch_request_o,
  output logic [pts_pkg::STATUS_W-1:0]        take_status_o,
  output logic                                higher_ready_o
);
  import pts_pkg::*;

  localparam int unsigned TIDW = $clog2(TASKS + 1);
  localparam int unsigned TIW  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CW   = $clog2(TASKS + 1);
  localparam int unsigned SW   = $clog2(SEMAPHORES + 1);
  localparam int unsigned SIW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam logic [TIDW-1:0] NO_TASK = TIDW'(TASKS);
  localparam logic [SW-1:0]   NO_SEM  = SW'(SEMAPHORES);

  state_e                 state_q, state_d;
  logic [TIW-1:0]         idx_q, idx_d;
  word_t                  word_q, word_d;
  mode_e                  mode_q [TASKS];
  mode_e                  mode_d [TASKS];
  logic [TICKS_W-1:0]     delay_q [TASKS];
  logic [TICKS_W-1:0]     delay_d [TASKS];
  logic [SW-1:0]          att_q [TASKS];
  logic [SW-1:0]          att_d [TASKS];
  logic [TICKS_W-1:0]     tmo_q [TASKS];
  logic [TICKS_W-1:0]     tmo_d [TASKS];
  logic [TASKS-1:0]       notmo_q, notmo_d;
  logic [SEMAPHORES-1:0]  avail_q, avail_d;
  logic [TIDW-1:0]        cur_q, cur_d;
  logic                   sw_q, sw_d;
  logic [STATUS_W-1:0]    status_q, status_d;

  qop_e                   qop;
  logic [TIDW-1:0]        qtask;
  logic [PRIORITY_LEVELS-1:0][CW-1:0]   qcnt;
  logic [PRIORITY_LEVELS-1:0][TIDW-1:0] qhead;

  logic                   last_idx;
  logic                   cur_valid;
  logic [TIW-1:0]         cur_idx;
  logic                   blockable;
  logic                   sid_ok;
  logic [SIW-1:0]         sid_idx;
  logic [SW-1:0]          att_cur;
  logic [LEVEL_W-1:0]     cur_level;

  pts_ready_q #(
    .TASKS           (TASKS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .TIDW            (TIDW),
    .CW              (CW)
  ) u_ready_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (qop),
    .task_i  (qtask),
    .level_i (level_of(prio_i, int'(qtask))),
    .cnt_o   (qcnt),
    .head_o  (qhead)
  );

  assign last_idx  = (int'(idx_q) == TASKS - 1);
  assign cur_valid = (int'(cur_q) < TASKS);
  assign cur_idx   = cur_q[TIW-1:0];
  assign blockable = cur_valid &&
                     (mode_q[cur_idx] == MODE_READY || mode_q[cur_idx] == MODE_RUNNING);
  assign sid_ok    = (int'(word_q.sem_id) < SEMAPHORES);
  assign sid_idx   = SIW'(word_q.sem_id);
  assign att_cur   = att_q[idx_q];
  assign cur_level = level_of(prio_i, int'(cur_q));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        idx_d = '0;
        priority case (word_q.command)
          CMD_START:    state_d = ST_START_Q;
          CMD_TICK:     state_d = ST_TICK_DLY;
          CMD_SCHEDULE: state_d = ST_SCHED_PICK;
          CMD_GIVE:     state_d = sid_ok ? ST_GIVE_SWEEP : ST_DONE;
          default:      state_d = ST_DONE;
        endcase
      end
      ST_START_Q, ST_TICK_DLY, ST_TICK_SEM, ST_GIVE_SWEEP: begin
        idx_d = idx_q + TIW'(1);
        if (last_idx) begin
          idx_d   = '0;
          state_d = (state_q == ST_TICK_DLY) ? ST_TICK_SEM : ST_DONE;
        end
      end
      ST_SCHED_PICK: state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath work of each state.
  always_comb begin
    word_d   = word_q;
    mode_d   = mode_q;
    delay_d  = delay_q;
    att_d    = att_q;
    tmo_d    = tmo_q;
    notmo_d  = notmo_q;
    avail_d  = avail_q;
    cur_d    = cur_q;
    sw_d     = sw_q;
    status_d = status_q;
    qop      = QOP_NONE;
    qtask    = TIDW'(idx_q);
    pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          word_d   = head_i.word;
          sw_d     = 1'b0;
          status_d = TAKE_ACQUIRED;
        end
      end
      ST_EXEC: begin
        priority case (word_q.command)
          CMD_START: begin
            qop = QOP_CLEAR;
            for (int t = 0; t < TASKS; t++) begin
              mode_d[t]  = MODE_READY;
              delay_d[t] = '0;
              att_d[t]   = NO_SEM;
              tmo_d[t]   = '0;
            end
            notmo_d = '0;
            avail_d = '0;
            cur_d   = NO_TASK;
            sw_d    = 1'b1;
          end
          CMD_TICK: sw_d = 1'b1;
          CMD_SCHEDULE: begin
            // Preempt the running task to the tail of its queue.
            if (cur_valid && mode_q[cur_idx] == MODE_RUNNING) begin
              mode_d[cur_idx] = MODE_READY;
              qop             = QOP_ENQ;
              qtask           = cur_q;
            end
            cur_d = NO_TASK;
          end
          CMD_DELAY: begin
            if (word_q.wait_ticks != '0 && blockable) begin
              if (mode_q[cur_idx] == MODE_READY) begin
                qop   = QOP_DEQ;
                qtask = cur_q;
              end
              mode_d[cur_idx]  = MODE_WAITING;
              delay_d[cur_idx] = word_q.wait_ticks;
              sw_d             = 1'b1;
            end
          end
          CMD_TAKE: begin
            if (!sid_ok) begin
              status_d = TAKE_NOT_AVAIL;
            end else if (avail_q[sid_idx]) begin
              avail_d[sid_idx] = 1'b0;
              if (cur_valid) att_d[cur_idx] = NO_SEM;
            end else if (word_q.wait_ticks != '0 || word_q.wait_forever) begin
              if (blockable) begin
                if (mode_q[cur_idx] == MODE_READY) begin
                  qop   = QOP_DEQ;
                  qtask = cur_q;
                end
                mode_d[cur_idx]  = MODE_WAITING;
                att_d[cur_idx]   = SW'(word_q.sem_id);
                tmo_d[cur_idx]   = word_q.wait_ticks;
                notmo_d[cur_idx] = word_q.wait_forever;
                status_d         = TAKE_BLOCKED;
                sw_d             = 1'b1;
              end else begin
                status_d = TAKE_NOT_AVAIL;
              end
            end else begin
              status_d = TAKE_NOT_AVAIL;
            end
          end
          CMD_GIVE: begin
            if (sid_ok) avail_d[sid_idx] = 1'b1;
          end
          default: ;
        endcase
      end
      ST_START_Q: qop = QOP_ENQ;
      ST_TICK_DLY: begin
        // Count down a delay; the task wakes when it reaches zero.
        if (mode_q[idx_q] == MODE_WAITING && delay_q[idx_q] != '0) begin
          delay_d[idx_q] = delay_q[idx_q] - TICKS_W'(1);
          if (delay_q[idx_q] == TICKS_W'(1)) begin
            mode_d[idx_q] = MODE_READY;
            qop           = QOP_ENQ;
          end
        end
      end
      ST_TICK_SEM, ST_GIVE_SWEEP: begin
        // Wake on a given semaphore, or on timeout during a tick.
        if (int'(att_cur) < SEMAPHORES) begin
          if (avail_q[att_cur[SIW-1:0]]) begin
            att_d[idx_q] = NO_SEM;
            if (mode_q[idx_q] == MODE_WAITING) begin
              mode_d[idx_q] = MODE_READY;
              qop           = QOP_ENQ;
            end
          end else if (state_q == ST_TICK_SEM && !notmo_q[idx_q]) begin
            if (tmo_q[idx_q] <= TICKS_W'(1)) begin
              tmo_d[idx_q] = '0;
              att_d[idx_q] = NO_SEM;
              if (mode_q[idx_q] == MODE_WAITING) begin
                mode_d[idx_q] = MODE_READY;
                qop           = QOP_ENQ;
              end
            end else begin
              tmo_d[idx_q] = tmo_q[idx_q] - TICKS_W'(1);
            end
          end
        end
      end
      ST_SCHED_PICK: begin
        // Run the head of the highest non-empty level.
        for (int l = 0; l < PRIORITY_LEVELS; l++) begin
          if (qcnt[l] != '0) begin
            qtask = qhead[l];
            cur_d = qhead[l];
          end
        end
        if (int'(cur_d) < TASKS) begin
          qop                     = QOP_DEQ;
          mode_d[cur_d[TIW-1:0]]  = MODE_RUNNING;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Result word, shown for the one cycle of the done state.
  always_comb begin
    done_o           = (state_q == ST_DONE);
    running_task_o   = RUN_TASK_W'(cur_q);
    switch_request_o = sw_q;
    take_status_o    = status_q;
    higher_ready_o   = 1'b0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (qcnt[l] != '0 && (!cur_valid || l > int'(cur_level))) begin
        higher_ready_o = 1'b1;
      end
    end
  end

  // Command word and per-task counters.
  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    delay_q <= delay_d;
    tmo_q   <= tmo_d;
  end

  // Control and task state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      cur_q    <= NO_TASK;
      sw_q     <= 1'b0;
      status_q <= TAKE_ACQUIRED;
      notmo_q  <= '0;
      avail_q  <= '0;
      for (int t = 0; t < TASKS; t++) begin
        mode_q[t] <= MODE_READY;
        att_q[t]  <= NO_SEM;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cur_q    <= cur_d;
      sw_q     <= sw_d;
      status_q <= status_d;
      notmo_q  <= notmo_d;
      avail_q  <= avail_d;
      mode_q   <= mode_d;
      att_q    <= att_d;
    end
  end

endmodule

FILE: rtl/priority_task_scheduler.sv
// Top level of the priority task scheduler: priority register, front queue
// and command executor. Uses pts_pkg, pts_front and pts_back.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+-------------------------
//  command   | command_i sem_id_i wait_ticks_i wait_forever_i | start_i high, busy_o low
//  result    | running_task_o switch_request_o take_status_o higher_ready_o | done_o
//  config    | cfg_we_i cfg_wdata_i                       | cfg_we_i high
//
// In the executor a start, a give and a tick sweep the task table one task per
// cycle (a tick sweeps the delays, then the semaphores), and a schedule picks
// the next task to run. The executor takes a word from the queue while idle.
// A two-word queue in front lets new words in while the executor works.
// Reset leaves every queue empty, all tasks ready and no task running.
// The result word is shown for one cycle on done_o; the receiver cannot stall.
module priority_task_scheduler #(
  parameter int unsigned TASKS           = pts_pkg::DEF_TASKS,
  parameter int unsigned PRIORITY_LEVELS = pts_pkg::DEF_LEVELS,
  parameter int unsigned SEMAPHORES      = pts_pkg::DEF_SEMAPHORES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [pts_pkg::CMD_W-1:0]          command_i,
  input  logic [pts_pkg::SEM_ID_W-1:0]       sem_id_i,
  input  logic [pts_pkg::TICKS_W-1:0]        wait_ticks_i,
  input  logic                               wait_forever_i,
  output logic                               done_o,
  output logic [pts_pkg::RUN_TASK_W-1:0]     running_task_o,
  output logic                               switch_request_o,
  output logic [pts_pkg::STATUS_W-1:0]       take_status_o,
  output logic                               higher_ready_o,
  input  logic                               cfg_we_i,
  input  logic [pts_pkg::PRIO_W-1:0]         cfg_wdata_i
);
  import pts_pkg::*;

  logic [PRIO_W-1:0] prio_q;
  word_t             in_word;
  front_head_t       head;
  logic              pop;

  assign in_word.command      = command_i;
  assign in_word.sem_id       = sem_id_i;
  assign in_word.wait_ticks   = wait_ticks_i;
  assign in_word.wait_forever = wait_forever_i;

  // Task priority register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= PRIO_RESET;
    end else if (cfg_we_i) begin
      prio_q <= cfg_wdata_i;
    end
  end

  pts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .word_i  (in_word),
    .busy_o  (busy_o),
    .head_o  (head),
    .pop_i   (pop)
  );

  pts_back #(
    .TASKS           (TASKS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .SEMAPHORES      (SEMAPHORES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .prio_i           (prio_q),
    .head_i           (head),
    .pop_o            (pop),
    .done_o           (done_o),
    .running_task_o   (running_task_o),
    .switch_request_o (switch_request_o),
    .take_status_o    (take_status_o),
    .higher_ready_o   (higher_ready_o)
  );

endmodule

FILE: rtl/pts_checker.sv
// Port-level checks of the priority task scheduler, bound to the top level.
// Uses pts_pkg.
module pts_checker #(
  parameter int unsigned TASKS = pts_pkg::DEF_TASKS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            done_o,
  input logic [pts_pkg::RUN_TASK_W-1:0]  running_task_o,
  input logic                            switch_request_o,
  input logic [pts_pkg::STATUS_W-1:0]    take_status_o
);
  import pts_pkg::*;

  // A result strobe is never followed directly by another one.
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  // The running task is a real task or the none marker.
  a_task_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(running_task_o) <= TASKS))
    else $error("running task out of range");

  // A blocked take always asks for a context switch.
  a_block_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && take_status_o == TAKE_BLOCKED) |-> switch_request_o)
    else $error("blocked take without switch request");

  // Status code three is never reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (take_status_o == TAKE_ACQUIRED || take_status_o == TAKE_NOT_AVAIL ||
                take_status_o == TAKE_BLOCKED))
    else $error("invalid take status");

endmodule

bind priority_task_scheduler pts_checker #(.TASKS(TASKS)) u_pts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .done_o           (done_o),
  .running_task_o   (running_task_o),
  .switch_request_o (switch_request_o),
  .take_status_o    (take_status_o)
);
